@@ rtl/gfau_pkg.sv @@
package gfau_pkg;

  localparam int FIELD_BITS = 8;
  localparam int ELEM_W     = FIELD_BITS;
  localparam int OP_W       = 8;
  localparam int EXP_W      = 32;
  localparam int CMD_W      = 2;
  localparam int POLY_W     = 8;
  localparam int NDIG       = (EXP_W + ELEM_W - 1) / ELEM_W;
  localparam int SUM_W      = ELEM_W + $clog2(NDIG) + 1;
  localparam int NFOLD      = 4;

  localparam logic [ELEM_W-1:0] ORDER      = {ELEM_W{1'b1}};
  localparam logic [ELEM_W-1:0] INV_EXP    = ORDER - ELEM_W'(1);
  localparam logic [ELEM_W-1:0] ELEM_ONE   = ELEM_W'(1);
  localparam logic [ELEM_W-1:0] ELEM_ZERO  = '0;
  localparam logic [POLY_W-1:0] POLY_RESET = POLY_W'(29);

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_MUL = 2'd1,
    CMD_INV = 2'd2,
    CMD_POW = 2'd3
  } cmd_t;

  typedef struct packed {
    logic  valid;
    logic  ovr;
    elem_t ovr_val;
    elem_t acc;
    elem_t base;
    elem_t exp;
  } stage_t;

  function automatic elem_t gf_mul(input elem_t a, input elem_t b, input elem_t poly);
    elem_t acc;
    elem_t sh;
    logic  carry;
    acc = '0;
    sh  = a;
    for (int i = 0; i < ELEM_W; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      carry = sh[ELEM_W-1];
      sh    = sh << 1;
      if (carry) begin
        sh = sh ^ poly;
      end
    end
    return acc;
  endfunction

endpackage

@@ rtl/gfau_front.sv @@
module gfau_front import gfau_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [CMD_W-1:0] cmd,
  input  logic [OP_W-1:0]  operand_a,
  input  logic [OP_W-1:0]  operand_b,
  input  logic [EXP_W-1:0] exponent,
  output stage_t           stage_out
);

  logic                     valid_r;
  stage_t                   pay_r;
  stage_t                   pay_nxt;
  elem_t                    a;
  elem_t                    b;
  elem_t                    e_red;
  logic [NDIG*ELEM_W-1:0]   e_pad;
  logic [SUM_W-1:0]         sum;
  cmd_t                     op;

  assign a     = ELEM_W'(operand_a);
  assign b     = ELEM_W'(operand_b);
  assign e_pad = (NDIG*ELEM_W)'(exponent);
  assign op    = cmd_t'(cmd);

  // exponent mod 2^M-1: digit sum, then end-around folds
  always_comb begin
    sum = '0;
    for (int i = 0; i < NDIG; i++) begin
      sum = sum + SUM_W'(e_pad[i*ELEM_W +: ELEM_W]);
    end
    for (int k = 0; k < NFOLD; k++) begin
      sum = SUM_W'(sum[ELEM_W-1:0]) + (sum >> ELEM_W);
    end
    e_red = (sum[ELEM_W-1:0] == ORDER) ? ELEM_ZERO : sum[ELEM_W-1:0];
  end

  always_comb begin
    pay_nxt         = '0;
    pay_nxt.valid   = 1'b1;
    pay_nxt.base    = a;
    pay_nxt.acc     = ELEM_ONE;
    unique case (op)
      CMD_ADD: begin
        pay_nxt.ovr     = 1'b1;
        pay_nxt.ovr_val = a ^ b;
      end
      CMD_MUL: begin
        pay_nxt.acc = b;
        pay_nxt.exp = ELEM_ONE;
      end
      CMD_INV: begin
        pay_nxt.exp     = INV_EXP;
        pay_nxt.ovr     = (a == ELEM_ZERO);
        pay_nxt.ovr_val = ELEM_ZERO;
      end
      CMD_POW: begin
        pay_nxt.exp     = e_red;
        pay_nxt.ovr     = (exponent == '0) || (a == ELEM_ZERO);
        pay_nxt.ovr_val = (exponent == '0) ? ELEM_ONE : ELEM_ZERO;
      end
      default: begin
        pay_nxt.ovr = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
  end

  always_comb begin
    stage_out       = pay_r;
    stage_out.valid = valid_r;
  end

endmodule

@@ rtl/gfau_cell.sv @@
module gfau_cell import gfau_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  elem_t  poly,
  input  stage_t stage_in,
  output stage_t stage_out
);

  logic   valid_r;
  stage_t pay_r;
  stage_t pay_nxt;

  // one square-and-multiply step on the low exponent bit
  always_comb begin
    pay_nxt      = stage_in;
    pay_nxt.acc  = stage_in.exp[0] ? gf_mul(stage_in.acc, stage_in.base, poly)
                                   : stage_in.acc;
    pay_nxt.base = gf_mul(stage_in.base, stage_in.base, poly);
    pay_nxt.exp  = stage_in.exp >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
  end

  always_comb begin
    stage_out       = pay_r;
    stage_out.valid = valid_r;
  end

endmodule

@@ rtl/gf2m_arithmetic_unit.sv @@
// From start to out_valid an item passes the front register, each cell register and the output register.
// Throughput: one item per cycle; busy stays low, start may be high every cycle.
// The chain holds one square-and-multiply cell per exponent bit.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) flushes all items and sets field_poly to 0x1D.
module gf2m_arithmetic_unit import gfau_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [OP_W-1:0]   in_operand_a,
  input  logic [OP_W-1:0]   in_operand_b,
  input  logic [EXP_W-1:0]  in_exponent,
  output logic              out_valid,
  output logic [OP_W-1:0]   out_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [POLY_W-1:0] cfg_field_poly
);

  logic [POLY_W-1:0] poly_r;
  elem_t             poly;
  stage_t            chain [ELEM_W+1];
  logic              out_valid_r;
  logic [OP_W-1:0]   out_result_r;
  logic [OP_W-1:0]   out_result_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign poly      = ELEM_W'(poly_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      poly_r <= cfg_field_poly;
    end
  end

  gfau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (start && !busy),
    .cmd       (in_cmd),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .exponent  (in_exponent),
    .stage_out (chain[0])
  );

  for (genvar g = 0; g < ELEM_W; g++) begin : g_cell
    gfau_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .poly      (poly),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  assign out_result_nxt = chain[ELEM_W].ovr ? OP_W'(chain[ELEM_W].ovr_val)
                                            : OP_W'(chain[ELEM_W].acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[ELEM_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule
